// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk with reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of i_clk while reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that the antecedent implies the consequent at the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ----- hdl/mct_pkg.sv -----
// ----------------------------------------------------------------------------
// Mesh cell triangulator package
// Types, constants, corner tables and helper functions of the triangulator.
// ----------------------------------------------------------------------------
package mct_pkg;

    localparam int MAX_CELL_POINTS = 32;
    localparam int MAX_RESULTS     = 30;
    localparam int PT_AW           = $clog2(MAX_CELL_POINTS);
    localparam int PS_W            = $clog2(MAX_CELL_POINTS + 1);
    localparam int TC_W            = 5;
    localparam int WORD_W          = 31;
    localparam int TYPE_W          = 8;
    localparam int NCELL_W         = 24;

    localparam logic [TYPE_W-1:0] CT_UNKNOWN  = 8'd0;
    localparam logic [TYPE_W-1:0] CT_TRIANGLE = 8'd5;
    localparam logic [TYPE_W-1:0] CT_QUAD     = 8'd9;
    localparam logic [TYPE_W-1:0] CT_TETRA    = 8'd10;
    localparam logic [TYPE_W-1:0] CT_VOXEL    = 8'd11;
    localparam logic [TYPE_W-1:0] CT_HEXA     = 8'd12;
    localparam logic [TYPE_W-1:0] CT_WEDGE    = 8'd13;
    localparam logic [TYPE_W-1:0] CT_PYRAMID  = 8'd14;

    localparam int NPT_TRI   = 3;
    localparam int NPT_QUAD  = 4;
    localparam int NPT_TETRA = 4;
    localparam int NPT_HEXA  = 8;
    localparam int NPT_WEDGE = 6;
    localparam int NPT_PYR   = 5;

    localparam int NTRI_TRI   = 1;
    localparam int NTRI_QUAD  = 2;
    localparam int NTRI_TETRA = 4;
    localparam int NTRI_HEXA  = 12;
    localparam int NTRI_WEDGE = 8;
    localparam int NTRI_PYR   = 6;

    // Each entry holds three corner numbers, one octal digit each.
    localparam logic [8:0] TRI_TAB [12] = '{0: 9'o012, default: 9'o000};
    localparam logic [8:0] QUAD_TAB [12] = '{0: 9'o012, 1: 9'o023, default: 9'o000};
    localparam logic [8:0] TET_TAB [12] = '{0: 9'o012, 1: 9'o023, 2: 9'o031, 3: 9'o132,
                                            default: 9'o000};
    localparam logic [8:0] HEX_TAB [12] = '{9'o031, 9'o132, 9'o457, 9'o567,
                                            9'o014, 9'o154, 9'o236, 9'o376,
                                            9'o043, 9'o347, 9'o125, 9'o265};
    localparam logic [8:0] WEDGE_TAB [12] = '{0: 9'o012, 1: 9'o354, 2: 9'o014, 3: 9'o043,
                                              4: 9'o125, 5: 9'o154, 6: 9'o025, 7: 9'o053,
                                              default: 9'o000};
    localparam logic [8:0] PYR_TAB [12] = '{0: 9'o021, 1: 9'o032, 2: 9'o014, 3: 9'o124,
                                            4: 9'o234, 5: 9'o304, default: 9'o000};

    typedef enum logic [2:0] {
        SH_TRI,
        SH_QUAD,
        SH_TET,
        SH_HEX,
        SH_VOX,
        SH_WEDGE,
        SH_PYR,
        SH_FAN
    } t_shape;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_EMIT,
        ST_ERR
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [TYPE_W-1:0] cell_type;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] vert_a;
        logic [WORD_W-1:0] vert_b;
        logic [WORD_W-1:0] vert_c;
        logic              status;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic take;
        logic rd;
        logic load_tri;
        logic load_err;
    } t_dp_cmd;

    typedef struct packed {
        logic start_emit;
        logic start_err;
        logic out_free;
        logic rd_last;
    } t_dp_sts;

    function automatic t_shape f_shape(input logic [TYPE_W-1:0] code,
                                       input logic [WORD_W-1:0] count);
        t_shape s;
        s = SH_FAN;
        case (code)
            CT_UNKNOWN: begin
                if (count == WORD_W'(NPT_TRI)) s = SH_TRI;
                else if (count == WORD_W'(NPT_QUAD)) s = SH_QUAD;
                else if (count == WORD_W'(NPT_HEXA)) s = SH_HEX;
            end
            CT_TRIANGLE: s = SH_TRI;
            CT_QUAD:     s = SH_QUAD;
            CT_TETRA:    s = SH_TET;
            CT_VOXEL:    s = SH_VOX;
            CT_HEXA:     s = SH_HEX;
            CT_WEDGE:    s = SH_WEDGE;
            CT_PYRAMID:  s = SH_PYR;
            default:     s = SH_FAN;
        endcase
        return s;
    endfunction

    function automatic logic [TC_W-1:0] f_tri_count(input t_shape s,
                                                    input logic [PS_W-1:0] n);
        int nn;
        int cnt;
        nn  = int'(n);
        cnt = 0;
        case (s)
            SH_TRI:   if (nn >= NPT_TRI) cnt = NTRI_TRI;
            SH_QUAD:  if (nn >= NPT_QUAD) cnt = NTRI_QUAD;
            SH_TET:   if (nn >= NPT_TETRA) cnt = NTRI_TETRA;
            SH_HEX:   if (nn >= NPT_HEXA) cnt = NTRI_HEXA;
            SH_VOX:   if (nn >= NPT_HEXA) cnt = NTRI_HEXA;
            SH_WEDGE: if (nn >= NPT_WEDGE) cnt = NTRI_WEDGE;
            SH_PYR:   if (nn >= NPT_PYR) cnt = NTRI_PYR;
            default: begin
                if (nn >= NPT_TRI) cnt = (nn - 2 > MAX_RESULTS) ? MAX_RESULTS : nn - 2;
            end
        endcase
        return TC_W'(cnt);
    endfunction

    function automatic logic [2:0] f_voxel_perm(input logic [2:0] c);
        return {c[2], c[1], c[0] ^ c[1]};
    endfunction

    // Returns the store addresses of the three corners of triangle k.
    function automatic logic [3*PT_AW-1:0] f_corners(input t_shape s,
                                                     input logic [TC_W-1:0] k);
        logic [8:0]       tc;
        logic [2:0]       c0;
        logic [2:0]       c1;
        logic [2:0]       c2;
        logic [PT_AW-1:0] k1;
        logic [PT_AW-1:0] k2;
        tc = 9'o000;
        k1 = PT_AW'(k) + PT_AW'(1);
        k2 = PT_AW'(k) + PT_AW'(2);
        case (s)
            SH_TRI:   tc = TRI_TAB[k[3:0]];
            SH_QUAD:  tc = QUAD_TAB[k[3:0]];
            SH_TET:   tc = TET_TAB[k[3:0]];
            SH_HEX:   tc = HEX_TAB[k[3:0]];
            SH_VOX:   tc = HEX_TAB[k[3:0]];
            SH_WEDGE: tc = WEDGE_TAB[k[3:0]];
            SH_PYR:   tc = PYR_TAB[k[3:0]];
            default:  tc = 9'o000;
        endcase
        c0 = tc[8:6];
        c1 = tc[5:3];
        c2 = tc[2:0];
        if (s == SH_VOX) begin
            c0 = f_voxel_perm(c0);
            c1 = f_voxel_perm(c1);
            c2 = f_voxel_perm(c2);
        end
        if (s == SH_FAN) begin
            return {PT_AW'(0), k1, k2};
        end
        return {PT_AW'(c0), PT_AW'(c1), PT_AW'(c2)};
    endfunction

endpackage

// ----- hdl/mct_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module mct_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/mct_dp.sv -----
// ----------------------------------------------------------------------------
// Mesh cell triangulator datapath
// Cell parsing state, vertex store, corner lookup and the output register.
// ----------------------------------------------------------------------------
module mct_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mct_pkg::t_dp_cmd               i_cmd,
    output mct_pkg::t_dp_sts               o_sts,
    input  mct_pkg::t_in_item              i_in_data,
    input  logic [mct_pkg::NCELL_W-1:0]    i_num_cells,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output mct_pkg::t_out_item             o_out_data
);
    import mct_pkg::*;

    logic                r_expect;
    logic [WORD_W-1:0]   r_needed;
    logic [PS_W-1:0]     r_seen;
    logic                r_skip;
    t_shape              r_shape;
    logic [NCELL_W-1:0]  r_cells_done;
    logic [TC_W-1:0]     r_tri_cnt;
    logic [TC_W-1:0]     r_rd_k;
    logic                r_rd_last;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                w_gate;
    logic                w_store;
    logic [PS_W-1:0]     w_seen_new;
    logic                w_complete;
    logic [TC_W-1:0]     w_cnt_new;
    logic [WORD_W-1:0]   w_needed_dec;
    logic                w_wr_en;
    logic [3*PT_AW-1:0]  w_corners;
    logic [WORD_W-1:0]   w_va;
    logic [WORD_W-1:0]   w_vb;
    logic [WORD_W-1:0]   w_vc;

    always_comb begin
        w_gate       = r_cells_done >= i_num_cells;
        w_store      = r_seen < PS_W'(MAX_CELL_POINTS);
        w_seen_new   = w_store ? r_seen + PS_W'(1) : r_seen;
        w_complete   = (WORD_W'(w_seen_new) >= r_needed)
                    || (w_seen_new >= PS_W'(MAX_CELL_POINTS));
        w_cnt_new    = f_tri_count(r_shape, w_seen_new);
        w_needed_dec = r_needed - WORD_W'(1);
        w_wr_en      = i_cmd.take && !r_expect && !r_skip && w_store;
        w_corners    = f_corners(r_shape, r_rd_k);

        o_sts.start_err  = i_cmd.take && r_expect && !w_gate
                        && (i_in_data.word > WORD_W'(MAX_CELL_POINTS));
        o_sts.start_emit = i_cmd.take && !r_expect && !r_skip && w_complete
                        && (w_cnt_new != '0);
        o_sts.out_free   = !r_out_valid || !i_out_stall;
        o_sts.rd_last    = r_rd_last;
    end

    mct_ram #(.WIDTH(WORD_W), .DEPTH(MAX_CELL_POINTS)) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_seen[PT_AW-1:0]),
        .i_wr_data (i_in_data.word),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (w_corners[3*PT_AW-1:2*PT_AW]),
        .o_rd_data (w_va)
    );

    mct_ram #(.WIDTH(WORD_W), .DEPTH(MAX_CELL_POINTS)) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_seen[PT_AW-1:0]),
        .i_wr_data (i_in_data.word),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (w_corners[2*PT_AW-1:PT_AW]),
        .o_rd_data (w_vb)
    );

    mct_ram #(.WIDTH(WORD_W), .DEPTH(MAX_CELL_POINTS)) u_ram_c (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_seen[PT_AW-1:0]),
        .i_wr_data (i_in_data.word),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (w_corners[PT_AW-1:0]),
        .o_rd_data (w_vc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect     <= 1'b1;
            r_needed     <= '0;
            r_seen       <= '0;
            r_skip       <= 1'b0;
            r_shape      <= SH_FAN;
            r_cells_done <= '0;
            r_tri_cnt    <= '0;
            r_rd_k       <= '0;
            r_rd_last    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                if (r_expect) begin
                    if (!w_gate) begin
                        r_shape  <= f_shape(i_in_data.cell_type, i_in_data.word);
                        r_needed <= i_in_data.word;
                        r_seen   <= '0;
                        if (i_in_data.word == '0) begin
                            r_cells_done <= r_cells_done + NCELL_W'(1);
                        end else begin
                            r_expect <= 1'b0;
                            if (i_in_data.word > WORD_W'(MAX_CELL_POINTS)) begin
                                r_skip <= 1'b1;
                            end
                        end
                    end
                end else if (r_skip) begin
                    r_needed <= w_needed_dec;
                    if (w_needed_dec == '0) begin
                        r_expect     <= 1'b1;
                        r_skip       <= 1'b0;
                        r_cells_done <= r_cells_done + NCELL_W'(1);
                    end
                end else begin
                    r_seen <= w_seen_new;
                    if (w_complete) begin
                        r_expect     <= 1'b1;
                        r_cells_done <= r_cells_done + NCELL_W'(1);
                        r_tri_cnt    <= w_cnt_new;
                        r_rd_k       <= '0;
                    end
                end
            end
            if (i_cmd.rd) begin
                r_rd_k    <= r_rd_k + TC_W'(1);
                r_rd_last <= (r_rd_k == r_tri_cnt - TC_W'(1));
            end
            if (i_cmd.load_tri || i_cmd.load_err) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tri) begin
            r_out.vert_a <= w_va;
            r_out.vert_b <= w_vb;
            r_out.vert_c <= w_vc;
            r_out.status <= 1'b0;
            r_out.last   <= r_rd_last;
        end else if (i_cmd.load_err) begin
            r_out.vert_a <= '0;
            r_out.vert_b <= '0;
            r_out.vert_c <= '0;
            r_out.status <= 1'b1;
            r_out.last   <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/mct_ctrl.sv -----
// ----------------------------------------------------------------------------
// Mesh cell triangulator controller
// Sequences word intake, triangle reads and output register loads.
// ----------------------------------------------------------------------------
module mct_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mct_pkg::t_dp_sts  i_sts,
    output mct_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);
    import mct_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.take     = 1'b0;
        o_cmd.rd       = 1'b0;
        o_cmd.load_tri = 1'b0;
        o_cmd.load_err = 1'b0;
        o_in_stall     = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
                if (i_sts.start_err) begin
                    n_state = ST_ERR;
                end else if (i_sts.start_emit) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_tri = 1'b1;
                    if (i_sts.rd_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.rd = 1'b1;
                    end
                end
            end
            ST_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_err = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/mesh_cell_triangulator_core.sv -----
// ----------------------------------------------------------------------------
// Mesh cell triangulator
// Turns a stream of cell connectivity words into triangles.
// ----------------------------------------------------------------------------
// Connectivity words are taken while the controller is idle. When a cell's
// last vertex arrives and the cell yields triangles, intake pauses for a
// corner lookup and then for each triangle in turn, since the three copies of
// the vertex store give one triangle's corners per read. An oversized cell's
// count word pauses intake while its error result is loaded. Output stalls
// stretch the emit phase, and new words are taken while the final result
// still waits in the output register. The vertex store needs no clearing
// after reset.
module mesh_cell_triangulator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  mct_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output mct_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mct_pkg::*;

`include "assert_macros.svh"

    logic [NCELL_W-1:0] r_num_cells;
    t_dp_cmd            w_cmd;
    t_dp_sts            w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cells <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_num_cells <= pwdata[NCELL_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(r_num_cells) : '0;

    mct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    mct_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_num_cells (r_num_cells),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    `ASSERT_NEXT(a_emit_stalls_input, i_in_valid && !o_in_stall && w_sts.start_emit, o_in_stall, "Input not stalled after cell completion")
    `ASSERT_CLK(a_cmd_exclusive, $onehot0({w_cmd.take, w_cmd.load_tri, w_cmd.load_err}), "Conflicting datapath commands")
    `ASSERT_CLK(a_err_result_form, (o_out_valid && o_out_data.status) |-> (o_out_data.last && (o_out_data.vert_a == '0)), "Malformed error result")

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Mesh cell triangulator testbench
// Drives connectivity words into the triangulator and checks every triangle
// against a cycle-free prediction of the cell decoding. Covers every cell shape,
// empty, short, padded and oversized cells, the cell limit register, random
// cells with random gaps on both sides, and a long output hold-off that backs
// up the request side.
// ----------------------------------------------------------------------------
module tb;
    import mct_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 20;
    localparam int REPORT_MAX    = 10;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_OFF      = 400;

    localparam logic [2:0]         ADDR_NUM_CELLS = 3'd0;
    localparam logic [WORD_W-1:0]  WORD_MAX       = {WORD_W{1'b1}};
    localparam logic [NCELL_W-1:0] CELLS_MAX      = {NCELL_W{1'b1}};

    localparam int QUAD_CORNERS [6]   = '{0, 1, 2, 0, 2, 3};
    localparam int TET_CORNERS [12]   = '{0, 1, 2, 0, 2, 3, 0, 3, 1, 1, 3, 2};
    localparam int HEX_CORNERS [36]   = '{0, 3, 1, 1, 3, 2, 4, 5, 7, 5, 6, 7,
                                          0, 1, 4, 1, 5, 4, 2, 3, 6, 3, 7, 6,
                                          0, 4, 3, 3, 4, 7, 1, 2, 5, 2, 6, 5};
    localparam int WEDGE_CORNERS [24] = '{0, 1, 2, 3, 5, 4, 0, 1, 4, 0, 4, 3,
                                          1, 2, 5, 1, 5, 4, 0, 2, 5, 0, 5, 3};
    localparam int PYR_CORNERS [18]   = '{0, 2, 1, 0, 3, 2, 0, 1, 4,
                                          1, 2, 4, 2, 3, 4, 3, 0, 4};
    localparam int VOXEL_ORDER [8]    = '{0, 1, 3, 2, 4, 5, 7, 6};

    localparam logic [TYPE_W-1:0] KNOWN_KINDS [8] = '{CT_UNKNOWN, CT_TRIANGLE, CT_QUAD,
                                                      CT_TETRA, CT_VOXEL, CT_HEXA,
                                                      CT_WEDGE, CT_PYRAMID};

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [NCELL_W-1:0] cell_limit  = '0;
    logic [NCELL_W-1:0] cells_done  = '0;
    logic               await_count = 1'b1;
    logic               skip_cell   = 1'b0;
    logic [WORD_W-1:0]  pts_needed  = '0;
    int                 pts_seen    = 0;
    logic [TYPE_W-1:0]  cell_kind   = '0;
    logic [WORD_W-1:0]  corner_store [MAX_CELL_POINTS];
    t_out_item          pending_tris [$];
    t_out_item          want;

    int errors      = 0;
    int hold_cycles = 0;
    int items_sent  = 0;
    int cycle_cnt   = 0;

    mesh_cell_triangulator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    function automatic int tri_total(input logic [TYPE_W-1:0] kind, input int n);
        case (kind)
            CT_TRIANGLE: return (n >= NPT_TRI) ? NTRI_TRI : 0;
            CT_QUAD:     return (n >= NPT_QUAD) ? NTRI_QUAD : 0;
            CT_TETRA:    return (n >= NPT_TETRA) ? NTRI_TETRA : 0;
            CT_HEXA:     return (n >= NPT_HEXA) ? NTRI_HEXA : 0;
            CT_VOXEL:    return (n >= NPT_HEXA) ? NTRI_HEXA : 0;
            CT_WEDGE:    return (n >= NPT_WEDGE) ? NTRI_WEDGE : 0;
            CT_PYRAMID:  return (n >= NPT_PYR) ? NTRI_PYR : 0;
            default:     return (n < NPT_TRI) ? 0 : (n - 2 > MAX_RESULTS) ? MAX_RESULTS : n - 2;
        endcase
    endfunction

    // A fan triangle k uses point 0 and points k+1 and k+2.
    function automatic int corner_of(input logic [TYPE_W-1:0] kind, input int idx);
        case (kind)
            CT_TRIANGLE: return idx;
            CT_QUAD:     return QUAD_CORNERS[idx];
            CT_TETRA:    return TET_CORNERS[idx];
            CT_HEXA:     return HEX_CORNERS[idx];
            CT_VOXEL:    return VOXEL_ORDER[HEX_CORNERS[idx]];
            CT_WEDGE:    return WEDGE_CORNERS[idx];
            CT_PYRAMID:  return PYR_CORNERS[idx];
            default:     return (idx % 3 == 0) ? 0 : idx / 3 + idx % 3;
        endcase
    endfunction

    task automatic queue_result(input t_out_item res);
        pending_tris = {pending_tris, res};
    endtask

    task automatic close_cell();
        await_count = 1'b1;
        skip_cell   = 1'b0;
        cells_done  = cells_done + 1'b1;
    endtask

    task automatic emit_triangles();
        int        ntri;
        t_out_item tri_out;
        ntri = tri_total(cell_kind, pts_seen);
        for (int k = 0; k < ntri; k++) begin
            tri_out.vert_a = corner_store[corner_of(cell_kind, 3 * k)];
            tri_out.vert_b = corner_store[corner_of(cell_kind, 3 * k + 1)];
            tri_out.vert_c = corner_store[corner_of(cell_kind, 3 * k + 2)];
            tri_out.status = 1'b0;
            tri_out.last   = (k == ntri - 1);
            queue_result(tri_out);
        end
    endtask

    task automatic triangulate_word(input t_in_item item);
        t_out_item skip_note;
        if (await_count) begin
            if (cells_done >= cell_limit) return;
            cell_kind = item.cell_type;
            if (item.cell_type == CT_UNKNOWN) begin
                if (item.word == WORD_W'(NPT_TRI)) cell_kind = CT_TRIANGLE;
                else if (item.word == WORD_W'(NPT_QUAD)) cell_kind = CT_QUAD;
                else if (item.word == WORD_W'(NPT_HEXA)) cell_kind = CT_HEXA;
            end
            pts_needed = item.word;
            pts_seen   = 0;
            if (item.word == '0) begin
                close_cell();
                return;
            end
            await_count = 1'b0;
            if (item.word > WORD_W'(MAX_CELL_POINTS)) begin
                skip_cell = 1'b1;
                skip_note = '0;
                skip_note.status = 1'b1;
                skip_note.last   = 1'b1;
                queue_result(skip_note);
            end
            return;
        end
        if (skip_cell) begin
            pts_needed = pts_needed - 1'b1;
            if (pts_needed == '0) close_cell();
            return;
        end
        if (pts_seen < MAX_CELL_POINTS) begin
            corner_store[pts_seen] = item.word;
            pts_seen++;
        end
        if (pts_seen >= pts_needed || pts_seen >= MAX_CELL_POINTS) begin
            emit_triangles();
            close_cell();
        end
    endtask

    task automatic log_error(input string msg);
        errors++;
        if (errors <= REPORT_MAX) $display("%0t: %s", $time, msg);
    endtask

    task automatic send_word(input logic [WORD_W-1:0] w, input logic [TYPE_W-1:0] t);
        int       gap;
        int       r;
        t_in_item item;
        r = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item.word      = w;
        item.cell_type = t;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        triangulate_word(item);
        items_sent++;
    endtask

    task automatic send_vertices(input int n);
        int                r;
        logic [WORD_W-1:0] w;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            w = (r == 0) ? '0 : (r == 1) ? WORD_MAX : WORD_W'($urandom());
            send_word(w, TYPE_W'($urandom()));
        end
    endtask

    task automatic send_cell(input logic [TYPE_W-1:0] t, input int count);
        send_word(WORD_W'(count), t);
        send_vertices(count);
    endtask

    task automatic write_num_cells(input logic [NCELL_W-1:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_NUM_CELLS;
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cell_limit = v;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_tris.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_limit_at_zero();
        write_num_cells('0);
        send_word(WORD_MAX, 8'hFF);
        send_cell(CT_TRIANGLE, NPT_TRI);
        drain_results();
    endtask

    task automatic test_each_shape();
        write_num_cells(CELLS_MAX);
        send_cell(CT_TRIANGLE, NPT_TRI);
        send_cell(CT_UNKNOWN, NPT_TRI);
        send_cell(CT_UNKNOWN, NPT_QUAD);
        send_cell(CT_UNKNOWN, NPT_HEXA);
        send_cell(CT_QUAD, NPT_QUAD);
        send_cell(CT_TETRA, NPT_TETRA);
        send_cell(CT_VOXEL, NPT_HEXA);
        send_cell(CT_HEXA, NPT_HEXA);
        send_cell(CT_WEDGE, NPT_WEDGE);
        send_cell(CT_PYRAMID, NPT_PYR);
        send_cell(8'd7, 5);
        drain_results();
    endtask

    task automatic test_odd_cells();
        send_cell(CT_HEXA, 0);
        send_cell(CT_UNKNOWN, 0);
        send_cell(CT_PYRAMID, 4);
        send_cell(8'd3, 2);
        send_cell(CT_TETRA, 1);
        send_cell(CT_TETRA, 7);
        send_cell(8'hFF, MAX_CELL_POINTS);
        send_cell(CT_HEXA, MAX_CELL_POINTS + 1);
        drain_results();
    endtask

    task automatic test_cell_limit();
        write_num_cells(cells_done + 2'd2);
        send_cell(CT_QUAD, NPT_QUAD);
        send_cell(CT_UNKNOWN, NPT_TRI);
        send_cell(CT_WEDGE, NPT_WEDGE);
        drain_results();
        // Lowering the limit inside a cell must not cut that cell short.
        write_num_cells(cells_done + 1'b1);
        send_word(WORD_W'(NPT_HEXA), CT_HEXA);
        send_vertices(4);
        drain_results();
        write_num_cells('0);
        send_vertices(4);
        send_cell(CT_TRIANGLE, NPT_TRI);
        drain_results();
    endtask

    task automatic test_backpressure();
        write_num_cells(CELLS_MAX);
        hold_cycles = HOLD_OFF;
        repeat (2) send_cell(CT_HEXA, NPT_HEXA);
        drain_results();
    endtask

    task automatic send_random_cell();
        logic [TYPE_W-1:0] t;
        int                idx;
        int                count;
        int                r;
        idx = $urandom_range(0, 8);
        t = (idx < 8) ? KNOWN_KINDS[idx] : TYPE_W'($urandom());
        case (t)
            CT_TRIANGLE: count = NPT_TRI;
            CT_QUAD:     count = NPT_QUAD;
            CT_TETRA:    count = NPT_TETRA;
            CT_VOXEL:    count = NPT_HEXA;
            CT_HEXA:     count = NPT_HEXA;
            CT_WEDGE:    count = NPT_WEDGE;
            CT_PYRAMID:  count = NPT_PYR;
            CT_UNKNOWN: begin
                r = $urandom_range(0, 3);
                count = (r == 0) ? NPT_TRI : (r == 1) ? NPT_QUAD :
                        (r == 2) ? NPT_HEXA : $urandom_range(0, 12);
            end
            default:     count = $urandom_range(3, 12);
        endcase
        r = $urandom_range(0, 99);
        if (r < 6) count = $urandom_range(MAX_CELL_POINTS + 1, MAX_CELL_POINTS + 8);
        else if (r < 20) count = $urandom_range(0, MAX_CELL_POINTS);
        send_cell(t, count);
    endtask

    task automatic test_random_cells();
        int first;
        write_num_cells(CELLS_MAX);
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) send_random_cell();
        drain_results();
    endtask

    initial begin
        int len;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                len = hold_cycles;
                hold_cycles = 0;
                i_out_stall <= 1'b1;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
                i_out_stall <= ($urandom_range(0, 2) == 0);
            end
            repeat (len) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_tris.size() == 0) begin
                log_error($sformatf("unexpected result a=%h b=%h c=%h status=%b last=%b",
                                    o_out_data.vert_a, o_out_data.vert_b, o_out_data.vert_c,
                                    o_out_data.status, o_out_data.last));
            end else begin
                want = pending_tris.pop_front();
                if (o_out_data.vert_a !== want.vert_a || o_out_data.vert_b !== want.vert_b ||
                    o_out_data.vert_c !== want.vert_c || o_out_data.status !== want.status ||
                    o_out_data.last !== want.last) begin
                    log_error($sformatf({"mismatch: expected a=%h b=%h c=%h status=%b last=%b,",
                                         " got a=%h b=%h c=%h status=%b last=%b"},
                                        want.vert_a, want.vert_b, want.vert_c,
                                        want.status, want.last,
                                        o_out_data.vert_a, o_out_data.vert_b,
                                        o_out_data.vert_c, o_out_data.status,
                                        o_out_data.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_limit_at_zero();
        test_each_shape();
        test_odd_cells();
        test_cell_limit();
        test_backpressure();
        test_random_cells();
        drain_results();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
